@@ sv/dspg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dspg_pkg
// Shared types and constants of the dual stepper pulse generator.
// ----------------------------------------------------------------------------
package dspg_pkg;

  localparam int unsigned TimerW = 16;
  localparam int unsigned ScaleW = 8;
  localparam int unsigned SpeedW = 3;
  localparam int unsigned CountW = 24;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 24;

  localparam logic [TimerW-1:0] IDLE_RESCHEDULE = 16'd1000;
  localparam logic [TimerW-1:0] MATCH_RESET = 16'd1000;
  localparam logic [SpeedW-1:0] SPEED_MAX = 3'd5;
  localparam logic [SpeedW-1:0] SPEED_MIN = 3'd1;
  localparam logic [CountW-1:0] COUNT_MAX = 24'hFF_FFFF;

  localparam logic [TimerW-1:0] PULSE_HIGH_RESET = 16'd16;
  localparam logic [ScaleW-1:0] SCALE_FIRST_RESET = 8'd19;
  localparam logic [ScaleW-1:0] SCALE_SECOND_RESET = 8'd5;
  localparam logic [CountW-1:0] STOP_COUNT_RESET = 24'd480000;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_SPEED = 2'd1,
    MODE_DIR   = 2'd2,
    MODE_START = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PULSE_HIGH   = 2'd0,
    CFG_SCALE_FIRST  = 2'd1,
    CFG_SCALE_SECOND = 2'd2,
    CFG_STOP_COUNT   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [TimerW-1:0] pulse_high;
    logic [ScaleW-1:0] scale_first;
    logic [ScaleW-1:0] scale_second;
    logic [CountW-1:0] stop_count;
  } cfg_t;

  // run flag and step count as they pass from one channel to the next
  typedef struct packed {
    logic              run;
    logic [CountW-1:0] total;
  } srv_t;

endpackage

@@ sv/dspg_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dspg_cfg_regs
// Configuration register file with a plain write port.
// ----------------------------------------------------------------------------
module dspg_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dspg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dspg_pkg::CfgDataW-1:0] cfg_wdata_i,
  output dspg_pkg::cfg_t                cfg_o
);

  dspg_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (dspg_pkg::cfg_idx_e'(cfg_idx_i))
        dspg_pkg::CFG_PULSE_HIGH:   cfg_d.pulse_high = cfg_wdata_i[dspg_pkg::TimerW-1:0];
        dspg_pkg::CFG_SCALE_FIRST:  cfg_d.scale_first = cfg_wdata_i[dspg_pkg::ScaleW-1:0];
        dspg_pkg::CFG_SCALE_SECOND: cfg_d.scale_second = cfg_wdata_i[dspg_pkg::ScaleW-1:0];
        dspg_pkg::CFG_STOP_COUNT:   cfg_d.stop_count = cfg_wdata_i[dspg_pkg::CountW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_high   <= dspg_pkg::PULSE_HIGH_RESET;
      cfg_q.scale_first  <= dspg_pkg::SCALE_FIRST_RESET;
      cfg_q.scale_second <= dspg_pkg::SCALE_SECOND_RESET;
      cfg_q.stop_count   <= dspg_pkg::STOP_COUNT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ sv/dspg_chan_serve.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dspg_chan_serve
// Compare-match service of one step channel: step level and next compare.
// ----------------------------------------------------------------------------
module dspg_chan_serve (
  input  logic                        match_i,
  input  logic                        count_en_i,
  input  logic                        level_i,
  input  logic [dspg_pkg::TimerW-1:0] matched_i,
  input  logic [dspg_pkg::TimerW-1:0] next_i,
  input  logic [dspg_pkg::ScaleW-1:0] scale_i,
  input  logic [dspg_pkg::SpeedW-1:0] speed_i,
  input  logic [dspg_pkg::TimerW-1:0] pulse_high_i,
  input  logic [dspg_pkg::CountW-1:0] stop_count_i,
  input  dspg_pkg::srv_t              srv_i,
  output logic                        level_o,
  output logic [dspg_pkg::TimerW-1:0] next_o,
  output dspg_pkg::srv_t              srv_o
);

  localparam int unsigned LowW = dspg_pkg::ScaleW + dspg_pkg::SpeedW;

  logic [LowW-1:0]               low_ticks;
  logic [dspg_pkg::CountW-1:0]   total_inc;

  assign low_ticks = LowW'(scale_i) * LowW'(speed_i);
  assign total_inc = (count_en_i && (srv_i.total != dspg_pkg::COUNT_MAX)) ?
                     srv_i.total + 1'b1 : srv_i.total;

  always_comb begin
    level_o = level_i;
    next_o  = next_i;
    srv_o   = srv_i;
    if (match_i) begin
      if (srv_i.run) begin
        if (!level_i) begin
          // rising step, limit checked on every rising edge
          level_o     = 1'b1;
          next_o      = matched_i + pulse_high_i;
          srv_o.total = total_inc;
          if (total_inc >= stop_count_i) begin
            srv_o.run = 1'b0;
          end
        end else begin
          level_o = 1'b0;
          next_o  = matched_i + dspg_pkg::TimerW'(low_ticks);
        end
      end else begin
        next_o = matched_i + dspg_pkg::IDLE_RESCHEDULE;
      end
    end
  end

endmodule

@@ sv/dual_stepper_pulse_generator_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_stepper_pulse_generator_core
// Step and direction generator for two stepper channels with shared timer.
// ----------------------------------------------------------------------------
// throughput: one word per cycle while the result word is not stalled; the input register
//   feeds the state update, and the state registers are the result register
// reset: asynchronous, active low; clears timer, run flag and step count,
//   compares to 1000, speed level 5, channel two direction high
module dual_stepper_pulse_generator_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dspg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dspg_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    mode_i,
  input  logic                          channel_select_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          step_first_o,
  output logic                          step_second_o,
  output logic                          dir_first_o,
  output logic                          dir_second_o,
  output logic                          running_o,
  output logic [dspg_pkg::SpeedW-1:0]   speed_level_o,
  output logic [dspg_pkg::CountW-1:0]   steps_done_o
);

  dspg_pkg::cfg_t cfg;

  dspg_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // input register
  logic       in_valid_q;
  logic [1:0] mode_q;
  logic       sel_q;
  logic       out_valid_q;
  logic       advance;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mode_q <= mode_i;
      sel_q  <= channel_select_i;
    end
  end

  // block state
  logic [dspg_pkg::TimerW-1:0] tick_q, tick_d;
  logic [dspg_pkg::TimerW-1:0] next1_q, next1_d, next2_q, next2_d;
  logic                        lvl1_q, lvl1_d, lvl2_q, lvl2_d;
  logic                        dir1_q, dir1_d, dir2_q, dir2_d;
  logic                        run_q, run_d;
  logic [dspg_pkg::SpeedW-1:0] speed_q, speed_d;
  logic                        falling_q, falling_d;
  logic [dspg_pkg::CountW-1:0] total_q, total_d;

  logic [dspg_pkg::TimerW-1:0] tick_inc;
  logic [dspg_pkg::TimerW-1:0] srv_next1, srv_next2;
  logic                        srv_lvl1, srv_lvl2;
  logic                        fall_sel;
  dspg_pkg::srv_t              srv_in, srv_mid, srv_out;

  assign tick_inc     = tick_q + 1'b1;
  assign srv_in.run   = run_q;
  assign srv_in.total = total_q;

  // channel one is served first and may clear the shared run flag before channel two is served
  dspg_chan_serve u_srv_first (
    .match_i      (tick_inc == next1_q),
    .count_en_i   (1'b0),
    .level_i      (lvl1_q),
    .matched_i    (tick_inc),
    .next_i       (next1_q),
    .scale_i      (cfg.scale_first),
    .speed_i      (speed_q),
    .pulse_high_i (cfg.pulse_high),
    .stop_count_i (cfg.stop_count),
    .srv_i        (srv_in),
    .level_o      (srv_lvl1),
    .next_o       (srv_next1),
    .srv_o        (srv_mid)
  );

  dspg_chan_serve u_srv_second (
    .match_i      (tick_inc == next2_q),
    .count_en_i   (1'b1),
    .level_i      (lvl2_q),
    .matched_i    (tick_inc),
    .next_i       (next2_q),
    .scale_i      (cfg.scale_second),
    .speed_i      (speed_q),
    .pulse_high_i (cfg.pulse_high),
    .stop_count_i (cfg.stop_count),
    .srv_i        (srv_mid),
    .level_o      (srv_lvl2),
    .next_o       (srv_next2),
    .srv_o        (srv_out)
  );

  // speed level bounces between the two end levels
  always_comb begin
    if (speed_q >= dspg_pkg::SPEED_MAX) begin
      fall_sel = 1'b1;
    end else if (speed_q <= dspg_pkg::SPEED_MIN) begin
      fall_sel = 1'b0;
    end else begin
      fall_sel = falling_q;
    end
  end

  always_comb begin
    tick_d    = tick_q;
    next1_d   = next1_q;
    next2_d   = next2_q;
    lvl1_d    = lvl1_q;
    lvl2_d    = lvl2_q;
    dir1_d    = dir1_q;
    dir2_d    = dir2_q;
    run_d     = run_q;
    speed_d   = speed_q;
    falling_d = falling_q;
    total_d   = total_q;
    case (dspg_pkg::mode_e'(mode_q))
      dspg_pkg::MODE_TICK: begin
        tick_d  = tick_inc;
        next1_d = srv_next1;
        next2_d = srv_next2;
        lvl1_d  = srv_lvl1;
        lvl2_d  = srv_lvl2;
        run_d   = srv_out.run;
        total_d = srv_out.total;
      end
      dspg_pkg::MODE_SPEED: begin
        falling_d = fall_sel;
        speed_d   = fall_sel ? speed_q - 1'b1 : speed_q + 1'b1;
      end
      dspg_pkg::MODE_DIR: begin
        if (sel_q) begin
          dir2_d = !dir2_q;
        end else begin
          dir1_d = !dir1_q;
        end
      end
      dspg_pkg::MODE_START: begin
        run_d   = !run_q;
        total_d = '0;
      end
      default: begin
        tick_d = tick_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q    <= '0;
      next1_q   <= dspg_pkg::MATCH_RESET;
      next2_q   <= dspg_pkg::MATCH_RESET;
      lvl1_q    <= 1'b0;
      lvl2_q    <= 1'b0;
      dir1_q    <= 1'b0;
      dir2_q    <= 1'b1;
      run_q     <= 1'b0;
      speed_q   <= dspg_pkg::SPEED_MAX;
      falling_q <= 1'b0;
      total_q   <= '0;
    end else if (advance) begin
      tick_q    <= tick_d;
      next1_q   <= next1_d;
      next2_q   <= next2_d;
      lvl1_q    <= lvl1_d;
      lvl2_q    <= lvl2_d;
      dir1_q    <= dir1_d;
      dir2_q    <= dir2_d;
      run_q     <= run_d;
      speed_q   <= speed_d;
      falling_q <= falling_d;
      total_q   <= total_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign step_first_o  = lvl1_q;
  assign step_second_o = lvl2_q;
  assign dir_first_o   = dir1_q;
  assign dir_second_o  = dir2_q;
  assign running_o     = run_q;
  assign speed_level_o = speed_q;
  assign steps_done_o  = total_q;

endmodule

@@ sv/dspg_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dspg_checker
// Port-level checks of the dual stepper pulse generator, bound to the core.
// ----------------------------------------------------------------------------
module dspg_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic [dspg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input logic [dspg_pkg::CfgDataW-1:0] cfg_wdata_i,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic [1:0]                    mode_i,
  input logic                          channel_select_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic                          step_first_o,
  input logic                          step_second_o,
  input logic                          dir_first_o,
  input logic                          dir_second_o,
  input logic                          running_o,
  input logic [dspg_pkg::SpeedW-1:0]   speed_level_o,
  input logic [dspg_pkg::CountW-1:0]   steps_done_o
);

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(steps_done_o) && $stable(speed_level_o))
    else $error("stalled result word changed");

  // step count only counts up by one or clears on a start press
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(steps_done_o) |->
      (steps_done_o == $past(steps_done_o) + 24'd1) || (steps_done_o == 24'd0))
    else $error("step count jumped");

  // speed level moves one level at a time and stays in range
  a_speed_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(speed_level_o) |->
      ((speed_level_o == $past(speed_level_o) + 3'd1) ||
       (speed_level_o == $past(speed_level_o) - 3'd1)) &&
      (speed_level_o >= dspg_pkg::SPEED_MIN) && (speed_level_o <= dspg_pkg::SPEED_MAX))
    else $error("speed level left its range or jumped");

endmodule

bind dual_stepper_pulse_generator_core dspg_checker u_dspg_checker (.*);
